// File: sv/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared widths, constants, codes and types of the space vector pwm block
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

    localparam int V_W     = 16;
    localparam int U_W     = 15;
    localparam int T_W     = 16;
    localparam int CNT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int MA_W    = 34;
    localparam int PROJ_W  = 26;
    localparam int SUM_W   = PROJ_W + 1;
    localparam int PT_W    = PROJ_W + T_W + 1;
    localparam int K_W     = PT_W + 18;
    localparam int DIV_NW  = PT_W + 16;
    localparam int DIV_DW  = SUM_W;
    localparam int DIV_QW  = DIV_NW + 1;
    localparam int DIV_LAT = DIV_NW + 2;
    localparam int TW      = 64;

    localparam logic signed [17:0] SQRT3_Q16   = 18'sd113512;
    localparam logic signed [17:0] SQRT3_2_Q16 = 18'sd56756;

    localparam logic [U_W-1:0] BUS_RST    = 15'd6144;
    localparam logic [T_W-1:0] PERIOD_RST = 16'd8400;

    localparam logic [IDX_W-1:0] REG_BUS    = 2'd0;
    localparam logic [IDX_W-1:0] REG_PERIOD = 2'd1;

    // sign code: bit 0 axis a, bit 1 axis b, bit 2 axis c
    localparam logic [2:0] CODE_NONE = 3'd0;
    localparam logic [2:0] CODE_A    = 3'd1;
    localparam logic [2:0] CODE_B    = 3'd2;
    localparam logic [2:0] CODE_AB   = 3'd3;
    localparam logic [2:0] CODE_C    = 3'd4;
    localparam logic [2:0] CODE_AC   = 3'd5;
    localparam logic [2:0] CODE_BC   = 3'd6;
    localparam logic [2:0] CODE_ALL  = 3'd7;

    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;
    localparam logic [2:0] SEC_6 = 3'd6;

    typedef struct packed {
        logic                     valid;
        logic [2:0]               code;
        logic [2:0]               sector;
        logic signed [PROJ_W-1:0] px;
        logic signed [PROJ_W-1:0] py;
    } proj_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] code;
        logic [2:0] sector;
        logic       sum_pos;
    } side_t;

endpackage

`default_nettype wire

// File: sv/svpwm_proj.sv
// ----------------------------------------------------------------------------
// svpwm_proj
// three-stage axis projection, sign code, sector and active vector pick
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_proj
    import svpwm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    valid,
    input  wire logic signed [V_W-1:0]   v_alpha,
    input  wire logic signed [V_W-1:0]   v_beta,
    output proj_t                        proj
);

    logic                     v1_reg;
    logic signed [MA_W-1:0]   ma_reg;
    logic signed [MA_W-1:0]   bs_reg;
    logic signed [PROJ_W-1:0] pa1_reg;

    logic                     v2_reg;
    logic signed [PROJ_W-1:0] pa_reg;
    logic signed [PROJ_W-1:0] pb_reg;
    logic signed [PROJ_W-1:0] pc_reg;

    proj_t                    proj_reg;
    proj_t                    proj_next;

    logic signed [MA_W-1:0]   mb_diff;
    logic signed [MA_W-1:0]   mc_diff;

    assign mb_diff = ma_reg - bs_reg;
    assign mc_diff = -ma_reg - bs_reg;

    always_comb
    begin
        proj_next.valid  = v2_reg;
        proj_next.code   = {pc_reg > 0, pb_reg > 0, pa_reg > 0};
        proj_next.sector = SEC_5;
        proj_next.px     = pb_reg;
        proj_next.py     = pc_reg;
        case (proj_next.code)
            CODE_A:
            begin
                proj_next.sector = SEC_2;
                proj_next.px     = -pc_reg;
                proj_next.py     = -pb_reg;
            end
            CODE_B:
            begin
                proj_next.sector = SEC_6;
                proj_next.px     = -pb_reg;
                proj_next.py     = -pa_reg;
            end
            CODE_AB:
            begin
                proj_next.sector = SEC_1;
                proj_next.px     = pc_reg;
                proj_next.py     = pa_reg;
            end
            CODE_C:
            begin
                proj_next.sector = SEC_4;
                proj_next.px     = -pa_reg;
                proj_next.py     = -pc_reg;
            end
            CODE_AC:
            begin
                proj_next.sector = SEC_3;
                proj_next.px     = pa_reg;
                proj_next.py     = pb_reg;
            end
            default:
            begin
                proj_next.sector = SEC_5;
                proj_next.px     = pb_reg;
                proj_next.py     = pc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            proj_reg <= '0;
        end
        else if (en)
        begin
            v1_reg   <= valid;
            v2_reg   <= v1_reg;
            proj_reg <= proj_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg  <= MA_W'(v_alpha * SQRT3_2_Q16);
            bs_reg  <= MA_W'($signed({v_beta, 15'b0}));
            pa1_reg <= PROJ_W'($signed({v_beta, 8'b0}));
            pa_reg  <= pa1_reg;
            pb_reg  <= mb_diff[MA_W-1:8];
            pc_reg  <= mc_diff[MA_W-1:8];
        end
    end

    assign proj = proj_reg;

endmodule

`default_nettype wire

// File: sv/svpwm_div.sv
// ----------------------------------------------------------------------------
// svpwm_div
// pipelined restoring divider, one quotient bit per stage, floor rounding
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_div
    import svpwm_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
)
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [NW-1:0] num,
    input  wire logic [DW-1:0]        den,
    output logic signed [NW:0]        quo
);

    logic [NW-1:0] dq_reg  [0:NW];
    logic [DW-1:0] rem_reg [0:NW];
    logic [DW-1:0] d_reg   [0:NW];
    logic          neg_reg [0:NW];

    logic [NW-1:0] dq_next  [1:NW];
    logic [DW-1:0] rem_next [1:NW];

    logic signed [NW:0] quo_reg;
    logic [NW:0]        mag_fin;

    always_comb
    begin
        for (int i = 1; i <= NW; i++)
        begin
            logic [DW+1:0] sh;
            logic [DW+1:0] diff;
            sh   = {1'b0, rem_reg[i-1], dq_reg[i-1][NW-1]};
            diff = sh - {2'b0, d_reg[i-1]};
            if (!diff[DW+1])
            begin
                rem_next[i] = diff[DW-1:0];
            end
            else
            begin
                rem_next[i] = sh[DW-1:0];
            end
            dq_next[i] = {dq_reg[i-1][NW-2:0], ~diff[DW+1]};
        end
    end

    assign mag_fin = {1'b0, dq_reg[NW]} + (NW+1)'(rem_reg[NW] != '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= num[NW-1];
            dq_reg[0]  <= num[NW-1] ? NW'(-num) : NW'(num);
            rem_reg[0] <= '0;
            d_reg[0]   <= den;
            for (int i = 1; i <= NW; i++)
            begin
                neg_reg[i] <= neg_reg[i-1];
                d_reg[i]   <= d_reg[i-1];
                dq_reg[i]  <= dq_next[i];
                rem_reg[i] <= rem_next[i];
            end
            quo_reg <= neg_reg[NW] ? -$signed(mag_fin) : $signed({1'b0, dq_reg[NW]});
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// File: sv/svpwm_sector_and_duty_top.sv
// ----------------------------------------------------------------------------
// svpwm_sector_and_duty_top
// pipeline: 3 projection stages, 2 scaling multiplier stages, 61-stage
//   divider bank, 4 segment stages, output register
// throughput: one word per cycle while not stalled; divider bank sets depth
// reset: clears all valid bits and loads bus value 6144 and 8400-count period
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_sector_and_duty_top
    import svpwm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic signed [V_W-1:0] v_alpha,
    input  wire logic signed [V_W-1:0] v_beta,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [2:0]                 sector,
    output logic [CNT_W-1:0]           duty_a,
    output logic [CNT_W-1:0]           duty_b,
    output logic [CNT_W-1:0]           duty_c
);

    logic [U_W-1:0] bus_voltage_reg;
    logic [T_W-1:0] pwm_period_reg;
    logic [U_W-1:0] u_eff;
    logic signed [TW-1:0] full;

    logic en;
    proj_t proj;

    // scaling
    logic                     v4_reg;
    logic [2:0]               code4_reg;
    logic [2:0]               sec4_reg;
    logic signed [PT_W-1:0]   ptx4_reg;
    logic signed [PT_W-1:0]   pty4_reg;
    logic signed [SUM_W-1:0]  sum4_reg;

    logic                     v5_reg;
    logic [2:0]               code5_reg;
    logic [2:0]               sec5_reg;
    logic signed [PT_W-1:0]   ptx5_reg;
    logic signed [PT_W-1:0]   pty5_reg;
    logic signed [SUM_W-1:0]  sum5_reg;
    logic signed [K_W-1:0]    kx5_reg;
    logic signed [K_W-1:0]    ky5_reg;

    logic signed [DIV_NW-1:0] num_x;
    logic signed [DIV_NW-1:0] num_y;
    logic signed [DIV_NW-1:0] num_rx;
    logic signed [DIV_NW-1:0] num_ry;
    logic [DIV_DW-1:0]        den_u;
    logic [DIV_DW-1:0]        den_s;
    logic                     sum_pos;

    logic signed [DIV_QW-1:0] qx;
    logic signed [DIV_QW-1:0] qy;
    logic signed [DIV_QW-1:0] rx;
    logic signed [DIV_QW-1:0] ry;

    side_t side_reg [0:DIV_LAT-1];
    side_t side_out;

    // segment stages
    logic signed [TW-1:0] qsum;
    logic                 rescale;
    logic                 v6_reg;
    logic [2:0]           code6_reg;
    logic [2:0]           sec6_reg;
    logic signed [TW-1:0] tx6_reg;
    logic signed [TW-1:0] ty6_reg;

    logic signed [TW-1:0] rest;
    logic                 v7_reg;
    logic [2:0]           code7_reg;
    logic [2:0]           sec7_reg;
    logic signed [TW-1:0] ta7_reg;
    logic signed [TW-1:0] hx7_reg;
    logic signed [TW-1:0] hy7_reg;

    logic                 v8_reg;
    logic [2:0]           code8_reg;
    logic [2:0]           sec8_reg;
    logic signed [TW-1:0] ta8_reg;
    logic signed [TW-1:0] tb8_reg;
    logic signed [TW-1:0] tc8_reg;

    logic signed [TW-1:0] da;
    logic signed [TW-1:0] db;
    logic signed [TW-1:0] dc;
    logic                 p_valid_reg;
    logic [2:0]           p_sec_reg;
    logic [CNT_W-1:0]     p_da_reg;
    logic [CNT_W-1:0]     p_db_reg;
    logic [CNT_W-1:0]     p_dc_reg;

    // output word and skid word
    logic                 out_valid_reg;
    logic [2:0]           sector_reg;
    logic [CNT_W-1:0]     duty_a_reg;
    logic [CNT_W-1:0]     duty_b_reg;
    logic [CNT_W-1:0]     duty_c_reg;
    logic                 skid_valid_reg;
    logic [2:0]           skid_sec_reg;
    logic [CNT_W-1:0]     skid_da_reg;
    logic [CNT_W-1:0]     skid_db_reg;
    logic [CNT_W-1:0]     skid_dc_reg;
    logic                 out_free;

    function automatic logic [CNT_W-1:0] to_counts(
        input logic signed [TW-1:0] v,
        input logic signed [TW-1:0] lim
    );
        logic signed [TW-1:0] c;
        begin
            c = v;
            if (v < 0)
            begin
                c = '0;
            end
            else if (v > lim)
            begin
                c = lim;
            end
            return c[31:16];
        end
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_voltage_reg <= BUS_RST;
            pwm_period_reg  <= PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BUS:    bus_voltage_reg <= cfg_wdata[U_W-1:0];
                REG_PERIOD: pwm_period_reg  <= cfg_wdata[T_W-1:0];
                default:    ;
            endcase
        end
    end

    assign u_eff = (bus_voltage_reg == '0) ? U_W'(1) : bus_voltage_reg;
    assign full  = $signed({16'b0, pwm_period_reg, 16'b0});

    assign en       = ~skid_valid_reg;
    assign in_stall = skid_valid_reg;

    svpwm_proj u_proj (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid   (in_valid),
        .v_alpha (v_alpha),
        .v_beta  (v_beta),
        .proj    (proj)
    );

    // period and sqrt3 scaling
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= proj.valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code4_reg <= proj.code;
            sec4_reg  <= proj.sector;
            ptx4_reg  <= proj.px * $signed({1'b0, pwm_period_reg});
            pty4_reg  <= proj.py * $signed({1'b0, pwm_period_reg});
            sum4_reg  <= SUM_W'(proj.px) + SUM_W'(proj.py);
            code5_reg <= code4_reg;
            sec5_reg  <= sec4_reg;
            ptx5_reg  <= ptx4_reg;
            pty5_reg  <= pty4_reg;
            sum5_reg  <= sum4_reg;
            kx5_reg   <= ptx4_reg * SQRT3_Q16;
            ky5_reg   <= pty4_reg * SQRT3_Q16;
        end
    end

    assign num_x   = DIV_NW'($signed(kx5_reg[K_W-1:8]));
    assign num_y   = DIV_NW'($signed(ky5_reg[K_W-1:8]));
    assign num_rx  = {ptx5_reg, 16'b0};
    assign num_ry  = {pty5_reg, 16'b0};
    assign den_u   = DIV_DW'(u_eff);
    assign sum_pos = (sum5_reg > 0);
    assign den_s   = sum_pos ? $unsigned(sum5_reg) : DIV_DW'(1);

    svpwm_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_x (
        .clk (clk), .en (en), .num (num_x), .den (den_u), .quo (qx)
    );

    svpwm_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_y (
        .clk (clk), .en (en), .num (num_y), .den (den_u), .quo (qy)
    );

    svpwm_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_rx (
        .clk (clk), .en (en), .num (num_rx), .den (den_s), .quo (rx)
    );

    svpwm_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_ry (
        .clk (clk), .en (en), .num (num_ry), .den (den_s), .quo (ry)
    );

    // sideband alongside the divider bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            side_reg[0].valid   <= v5_reg;
            side_reg[0].code    <= code5_reg;
            side_reg[0].sector  <= sec5_reg;
            side_reg[0].sum_pos <= sum_pos;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign side_out = side_reg[DIV_LAT-1];

    // overmodulation pick
    assign qsum    = TW'(qx) + TW'(qy);
    assign rescale = (qsum > full) && side_out.sum_pos;

    // segment times
    assign rest = full - tx6_reg - ty6_reg;

    always_comb
    begin
        da = '0;
        db = '0;
        dc = '0;
        case (code8_reg)
            CODE_A:
            begin
                da = tb8_reg; db = ta8_reg; dc = tc8_reg;
            end
            CODE_B:
            begin
                da = ta8_reg; db = tc8_reg; dc = tb8_reg;
            end
            CODE_AB:
            begin
                da = ta8_reg; db = tb8_reg; dc = tc8_reg;
            end
            CODE_C:
            begin
                da = tc8_reg; db = tb8_reg; dc = ta8_reg;
            end
            CODE_AC:
            begin
                da = tc8_reg; db = ta8_reg; dc = tb8_reg;
            end
            CODE_BC:
            begin
                da = tb8_reg; db = tc8_reg; dc = ta8_reg;
            end
            default:
            begin
                da = '0; db = '0; dc = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg      <= side_out.valid;
            v7_reg      <= v6_reg;
            v8_reg      <= v7_reg;
            p_valid_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code6_reg <= side_out.code;
            sec6_reg  <= side_out.sector;
            tx6_reg   <= rescale ? TW'(rx) : TW'(qx);
            ty6_reg   <= rescale ? TW'(ry) : TW'(qy);
            code7_reg <= code6_reg;
            sec7_reg  <= sec6_reg;
            ta7_reg   <= rest >>> 2;
            hx7_reg   <= tx6_reg >>> 1;
            hy7_reg   <= ty6_reg >>> 1;
            code8_reg <= code7_reg;
            sec8_reg  <= sec7_reg;
            ta8_reg   <= ta7_reg;
            tb8_reg   <= ta7_reg + hx7_reg;
            tc8_reg   <= ta7_reg + hx7_reg + hy7_reg;
            p_sec_reg <= sec8_reg;
            p_da_reg  <= to_counts(da, full);
            p_db_reg  <= to_counts(db, full);
            p_dc_reg  <= to_counts(dc, full);
        end
    end

    // output word with skid word behind it
    assign out_free = ~out_valid_reg | ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg | p_valid_reg;
            skid_valid_reg <= 1'b0;
        end
        else if (en && p_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                sector_reg <= skid_sec_reg;
                duty_a_reg <= skid_da_reg;
                duty_b_reg <= skid_db_reg;
                duty_c_reg <= skid_dc_reg;
            end
            else
            begin
                sector_reg <= p_sec_reg;
                duty_a_reg <= p_da_reg;
                duty_b_reg <= p_db_reg;
                duty_c_reg <= p_dc_reg;
            end
        end
        else if (en && p_valid_reg)
        begin
            skid_sec_reg <= p_sec_reg;
            skid_da_reg  <= p_da_reg;
            skid_db_reg  <= p_db_reg;
            skid_dc_reg  <= p_dc_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sector    = sector_reg;
    assign duty_a    = duty_a_reg;
    assign duty_b    = duty_b_reg;
    assign duty_c    = duty_c_reg;

    // checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without output word");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall && p_valid_reg))
        else $error("skid filled without a stalled output");

    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sector_reg != 3'd0 && sector_reg != 3'd7))
        else $error("sector out of range");

    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (duty_a_reg <= pwm_period_reg && duty_b_reg <= pwm_period_reg
                           && duty_c_reg <= pwm_period_reg))
        else $error("compare value above period");

endmodule

`default_nettype wire

// File: test/svpwm_checker.sv
// ----------------------------------------------------------------------------
// svpwm_checker
// watches the config port and both word channels of the svpwm block, predicts
// sector and compare values for every accepted input word and compares them in
// order with the output words
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_checker
    import svpwm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic signed [V_W-1:0] v_alpha,
    input  wire logic signed [V_W-1:0] v_beta,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [2:0]            sector,
    input  wire logic [CNT_W-1:0]      duty_a,
    input  wire logic [CNT_W-1:0]      duty_b,
    input  wire logic [CNT_W-1:0]      duty_c,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]       sector;
        logic [CNT_W-1:0] da;
        logic [CNT_W-1:0] db;
        logic [CNT_W-1:0] dc;
    } duty_word_t;

    logic [U_W-1:0] bus_q;
    logic [T_W-1:0] period_q;
    duty_word_t     duty_fifo[$];

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q -= 1;
        return q;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_counts(longint v, longint full);
        if (v < 0)
            v = 0;
        if (v > full)
            v = full;
        return v[16 +: CNT_W];
    endfunction

    function automatic duty_word_t svpwm_duty(logic signed [V_W-1:0] va,
                                              logic signed [V_W-1:0] vb);
        longint a, b, u, t, full, pa, pb, pc, px, py, tx, ty, ta, tb, tc, k, den;
        longint da, db, dc;
        logic [2:0] code;
        duty_word_t w;
        a = va;
        b = vb;
        u = bus_q;
        t = period_q;
        full = t * 65536;
        if (u == 0)
            u = 1;
        pa = b * 256;
        pb = fdiv(a * 56756 - b * 32768, 256);
        pc = fdiv(-a * 56756 - b * 32768, 256);
        code = {pc > 0, pb > 0, pa > 0};
        case (code)
            CODE_A:  begin w.sector = SEC_2; px = -pc; py = -pb; end
            CODE_B:  begin w.sector = SEC_6; px = -pb; py = -pa; end
            CODE_AB: begin w.sector = SEC_1; px = pc;  py = pa;  end
            CODE_C:  begin w.sector = SEC_4; px = -pa; py = -pc; end
            CODE_AC: begin w.sector = SEC_3; px = pa;  py = pb;  end
            default: begin w.sector = SEC_5; px = pb;  py = pc;  end
        endcase
        k = 113512 * t;
        den = 256 * u;
        tx = fdiv(k * px, den);
        ty = fdiv(k * py, den);
        if (tx + ty > full && px + py > 0)
        begin
            tx = fdiv(px * full, px + py);
            ty = fdiv(py * full, px + py);
        end
        ta = fdiv(full - tx - ty, 4);
        tb = ta + fdiv(tx, 2);
        tc = tb + fdiv(ty, 2);
        case (code)
            CODE_A:  begin da = tb; db = ta; dc = tc; end
            CODE_B:  begin da = ta; db = tc; dc = tb; end
            CODE_AB: begin da = ta; db = tb; dc = tc; end
            CODE_C:  begin da = tc; db = tb; dc = ta; end
            CODE_AC: begin da = tc; db = ta; dc = tb; end
            CODE_BC: begin da = tb; db = tc; dc = ta; end
            default: begin da = 0;  db = 0;  dc = 0;  end
        endcase
        w.da = clamp_counts(da, full);
        w.db = clamp_counts(db, full);
        w.dc = clamp_counts(dc, full);
        return w;
    endfunction

    assign pending = duty_fifo.size();

    always @(posedge clk or negedge rst_n)
    begin
        duty_word_t want;
        duty_word_t got;
        if (!rst_n)
        begin
            bus_q      = BUS_RST;
            period_q   = PERIOD_RST;
            fail_count = 0;
            duty_fifo.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{sector, duty_a, duty_b, duty_c};
                if (duty_fifo.size() == 0)
                begin
                    $display("%0t: unexpected word, actual %p", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = duty_fifo.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch, expected %p actual %p", $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                duty_fifo.push_back(svpwm_duty(v_alpha, v_beta));
            if (cfg_we)
            begin
                if (cfg_index == REG_BUS)
                    bus_q = cfg_wdata[U_W-1:0];
                else if (cfg_index == REG_PERIOD)
                    period_q = cfg_wdata[T_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives voltage pairs and config writes into the svpwm block under several
// idle and stall patterns; the checker predicts and compares every word
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import svpwm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 600000;
    localparam int DRAIN = 90;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [IDX_W-1:0]      cfg_index = REG_BUS;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic signed [V_W-1:0] v_alpha = '0;
    logic signed [V_W-1:0] v_beta = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            sector;
    logic [CNT_W-1:0]      duty_a;
    logic [CNT_W-1:0]      duty_b;
    logic [CNT_W-1:0]      duty_c;
    int                    fail_count;
    int                    pending;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    svpwm_sector_and_duty_top i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
        .v_alpha(v_alpha), .v_beta(v_beta), .out_valid(out_valid),
        .out_stall(out_stall), .sector(sector), .duty_a(duty_a),
        .duty_b(duty_b), .duty_c(duty_c)
    );

    svpwm_checker i_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
        .v_alpha(v_alpha), .v_beta(v_beta), .out_valid(out_valid),
        .out_stall(out_stall), .sector(sector), .duty_a(duty_a),
        .duty_b(duty_b), .duty_c(duty_c), .fail_count(fail_count),
        .pending(pending)
    );

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_word(logic signed [V_W-1:0] a, logic signed [V_W-1:0] b);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        v_alpha  = a;
        v_beta   = b;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // idle the input channel, drain and let the pipeline empty before a write
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_words(int n);
        logic signed [V_W-1:0] a;
        logic signed [V_W-1:0] b;
        int span;
        int ai;
        int bi;
        repeat (n)
        begin
            a = V_W'($urandom);
            b = V_W'($urandom);
            // mostly moderate vectors so that the rescale is not always taken
            if ($urandom_range(3) != 0)
            begin
                span = 1 << $urandom_range(15, 4);
                ai = $signed($urandom_range(2 * span)) - span;
                bi = $signed($urandom_range(2 * span)) - span;
                if (ai > 32767) ai = 32767;
                if (bi > 32767) bi = -32768;
                a = V_W'(ai);
                b = V_W'(bi);
            end
            send_word(a, b);
        end
    endtask

    initial
    begin
        logic signed [V_W-1:0] da[$];
        logic signed [V_W-1:0] db[$];
        da = '{0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768,
               1, 0, -1, 0, 443, 0, -443, -443, 0, 443, 0, 200, 5000, -9000};
        db = '{0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767,
               0, 1, 0, -1, 256, 512, 256, -256, -512, -256, -256, 100, -7000, 3000};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (da[i])
            send_word(da[i], db[i]);
        random_words(100);

        settle();
        write_reg(REG_BUS, 16'd1);
        write_reg(REG_PERIOD, 16'd65535);
        idle_pct = 80;
        foreach (da[i])
            send_word(da[i], db[i]);
        random_words(80);

        settle();
        write_reg(REG_BUS, 16'h7fff);
        write_reg(REG_PERIOD, 16'd1);
        idle_pct  = 0;
        stall_pct = 80;
        random_words(100);

        settle();
        // top bit of the bus field is dropped, so this gives a zero bus
        write_reg(REG_BUS, 16'h8000);
        write_reg(REG_PERIOD, 16'd0);
        idle_pct  = 16;
        stall_pct = 16;
        foreach (da[i])
            send_word(da[i], db[i]);
        random_words(60);

        settle();
        write_reg(REG_BUS, 16'd0);
        write_reg(REG_PERIOD, 16'd1200);
        write_reg(2'd2, 16'hffff);
        write_reg(2'd3, 16'h5555);
        idle_pct  = 0;
        stall_pct = 0;
        random_words(80);

        settle();
        write_reg(REG_BUS, CFG_W'($urandom));
        write_reg(REG_PERIOD, CFG_W'($urandom));
        idle_pct  = 80;
        stall_pct = 80;
        random_words(60);

        settle();
        write_reg(REG_BUS, 16'd3072);
        write_reg(REG_PERIOD, 16'd40000);
        idle_pct  = 16;
        stall_pct = 16;
        random_words(120);

        settle();
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
